### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/htfd_pkg.sv
package htfd_pkg;

    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_RH   = 1'b1
    } t_kind;

    // CRC-8, polynomial x^8+x^5+x^4+1, low byte of the polynomial word
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] STATUS_MASK = 8'hFC;

    // Gains and offsets in hundredths, as integers; the gain product has 16 fraction bits
    localparam logic [14:0]        T_GAIN    = 15'd17572;
    localparam logic [14:0]        RH_GAIN   = 15'd12500;
    localparam logic signed [15:0] T_OFFSET  = -16'sd4685;
    localparam logic signed [15:0] RH_OFFSET = -16'sd600;

endpackage

### hdl/htfd_crc8_step.sv
module htfd_crc8_step (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);
    import htfd_pkg::*;

    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_byte;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

### hdl/humidity_temp_frame_decode_core.sv
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+----------------------------------------
// frame in | input     | i_valid / o_stall   | i_opcode, i_data_high, i_data_low,
//          |           |                     | i_crc_byte
// result   | output    | o_valid / i_stall   | o_crc_ok, o_raw_value,
//          |           |                     | o_reading_hundredths
//
// One word enters per cycle unless o_stall is high; words pass stages 1, 2, 3 in order.
// Stage 1 runs the CRC over the high byte, stage 2 the CRC over the low byte
// and the 15x16 gain multiply, stage 3 the offset add into the output register.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// i_stall holds the output register; stalls ripple back only through full
// stages, so bubbles are squeezed out and no word is dropped or repeated.
module humidity_temp_frame_decode_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_data_high,
    input  logic [7:0]         i_data_low,
    input  logic [7:0]         i_crc_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_crc_ok,
    output logic [15:0]        o_raw_value,
    output logic signed [14:0] o_reading_hundredths
);
    import htfd_pkg::*;

    // Stage valid bits and load enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // Stage 1 payload
    t_kind       r_kind1;
    logic [7:0]  r_crc1;
    logic [7:0]  r_lo1;
    logic [7:0]  r_chk1;
    logic [15:0] r_raw1;

    // Stage 2 payload
    t_kind       r_kind2;
    logic        r_ok2;
    logic [15:0] r_raw2;
    logic [30:0] r_prod2;

    // Stage 3 (output) payload
    logic               r_ok3;
    logic [15:0]        r_raw3;
    logic signed [14:0] r_reading3;

    logic [7:0]  n_crc1;
    logic [7:0]  n_crc2;
    logic [14:0] gain;
    logic signed [15:0] offset;
    logic signed [15:0] n_reading;

    // Advance a stage when it is empty or the next one advances
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: CRC over the high byte, strip the status bits
    htfd_crc8_step u_crc_hi (
        .i_crc  (8'h00),
        .i_byte (i_data_high),
        .o_crc  (n_crc1)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_kind1 <= t_kind'(i_opcode);
            r_crc1  <= n_crc1;
            r_lo1   <= i_data_low;
            r_chk1  <= i_crc_byte;
            r_raw1  <= {i_data_high, i_data_low & STATUS_MASK};
        end
    end

    // Stage 2: finish the CRC over the low byte as received; scale by the gain
    htfd_crc8_step u_crc_lo (
        .i_crc  (r_crc1),
        .i_byte (r_lo1),
        .o_crc  (n_crc2)
    );

    always_comb begin
        case (r_kind1)
            KIND_TEMP: gain = T_GAIN;
            KIND_RH:   gain = RH_GAIN;
            default:   gain = T_GAIN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_kind2 <= r_kind1;
            r_ok2   <= (n_crc2 == r_chk1);
            r_raw2  <= r_raw1;
            r_prod2 <= 31'(gain) * 31'(r_raw1);
        end
    end

    // Stage 3: drop the fraction bits and add the offset
    always_comb begin
        case (r_kind2)
            KIND_TEMP: offset = T_OFFSET;
            KIND_RH:   offset = RH_OFFSET;
            default:   offset = T_OFFSET;
        endcase
        n_reading = $signed({1'b0, r_prod2[30:16]}) + offset;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ok3      <= r_ok2;
            r_raw3     <= r_raw2;
            r_reading3 <= n_reading[14:0];
        end
    end

    assign o_valid              = r_v3;
    assign o_crc_ok             = r_ok3;
    assign o_raw_value          = r_raw3;
    assign o_reading_hundredths = r_reading3;

endmodule

### hdl/htfd_checker.sv
`include "assert_macros.svh"

module htfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_crc_ok,
    input logic [15:0]        o_raw_value,
    input logic signed [14:0] o_reading_hundredths
);

    logic [31:0] out_word;
    logic        reading_in_range;

    assign out_word         = {o_crc_ok, o_raw_value, o_reading_hundredths};
    assign reading_in_range = (o_reading_hundredths >= -15'sd4685) &&
                              (o_reading_hundredths <= 15'sd12887);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

    // Status bits never reach the raw word
    `ASSERT_IMPLY(a_status_clear, i_clk, i_rst_n, o_valid, o_raw_value[1:0] == 2'b00)

    // Reading stays inside the conversion range
    `ASSERT_IMPLY(a_reading_range, i_clk, i_rst_n, o_valid, reading_in_range)

    // Input side never stalls while the output side is free
    `ASSERT_IMPLY(a_no_false_stall, i_clk, i_rst_n, !i_stall, !o_stall)

endmodule

bind humidity_temp_frame_decode_core htfd_checker u_htfd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_crc_ok             (o_crc_ok),
    .o_raw_value          (o_raw_value),
    .o_reading_hundredths (o_reading_hundredths)
);

### tb/humidity_temp_frame_decode_core_tb.sv
`timescale 1ns / 100ps

module humidity_temp_frame_decode_core_tb;
    import htfd_pkg::*;

    typedef struct {
        t_kind     kind;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] chk;
    } t_frame;

    typedef struct {
        logic               crc_ok;
        logic [15:0]        raw;
        logic signed [14:0] reading;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = 1'b0;
    logic [7:0]         i_data_high = 8'h00;
    logic [7:0]         i_data_low = 8'h00;
    logic [7:0]         i_crc_byte = 8'h00;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_crc_ok;
    logic [15:0]        o_raw_value;
    logic signed [14:0] o_reading_hundredths;

    t_frame   frame_q[$];
    t_reading reading_q[$];
    t_frame   next_frame;
    t_reading got;
    t_reading want;
    logic     word_taken = 1'b0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       sent_count = 0;
    int       cycle_count = 0;
    int       error_count = 0;

    humidity_temp_frame_decode_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_opcode             (i_opcode),
        .i_data_high          (i_data_high),
        .i_data_low           (i_data_low),
        .i_crc_byte           (i_crc_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_crc_ok             (o_crc_ok),
        .o_raw_value          (o_raw_value),
        .o_reading_hundredths (o_reading_hundredths)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // CRC-8 over both data bytes, MSB first, start value zero
    function automatic logic [7:0] frame_crc(logic [7:0] hi, logic [7:0] lo);
        logic [7:0] crc;
        crc = hi;
        for (int b = 0; b < 16; b++) begin
            if (b == 8)
                crc = crc ^ lo;
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    function automatic t_reading decode_frame(t_frame f);
        t_reading    r;
        logic [31:0] prod;
        int          scaled;
        r.crc_ok = (frame_crc(f.hi, f.lo) == f.chk);
        r.raw    = {f.hi, f.lo & STATUS_MASK};
        if (f.kind == KIND_TEMP) begin
            prod   = 32'(T_GAIN) * 32'(r.raw);
            scaled = int'(T_OFFSET) + int'(prod[31:16]);
        end else begin
            prod   = 32'(RH_GAIN) * 32'(r.raw);
            scaled = int'(RH_OFFSET) + int'(prod[31:16]);
        end
        r.reading = scaled[14:0];
        return r;
    endfunction

    // Build a frame; a bad one gets a checksum with at least one bit flipped
    function automatic t_frame make_frame(t_kind kind, logic [7:0] hi, logic [7:0] lo,
                                          bit good);
        t_frame f;
        f.kind = kind;
        f.hi   = hi;
        f.lo   = lo;
        f.chk  = frame_crc(hi, lo);
        if (!good)
            f.chk = f.chk ^ 8'($urandom_range(1, 255));
        return f;
    endfunction

    // Mostly back-to-back, some short holes, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_field(string name, longint exp_v, longint act_v);
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        error_count++;
    endtask

    // Driver: present one word at a time, hold it until taken, then idle for a gap that may be zero
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !word_taken) begin
            // stalled: hold the word as is
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (frame_q.size() > 0) begin
            next_frame = frame_q.pop_front();
            i_opcode    <= next_frame.kind;
            i_data_high <= next_frame.hi;
            i_data_low  <= next_frame.lo;
            i_crc_byte  <= next_frame.chk;
            i_valid     <= 1'b1;
            // every few hundred words, run a stretch with no holes at all
            gap_left    <= ((sent_count % 300) < 60) ? 0 : pick_gap();
            sent_count  <= sent_count + 1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure, with its own quiet stretches
    always @(negedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= ((cycle_count % 1000) < 150) ? 0 : pick_gap();
        end
    end

    // Monitor: check each result word, then log each accepted frame word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got.crc_ok  = o_crc_ok;
            got.raw     = o_raw_value;
            got.reading = o_reading_hundredths;
            if (reading_q.size() == 0) begin
                $display("%0t unexpected result: crc_ok %0b raw %0h reading %0d",
                         $time, got.crc_ok, got.raw, got.reading);
                error_count++;
            end else begin
                want = reading_q.pop_front();
                if (got.crc_ok !== want.crc_ok)
                    report_field("crc_ok", want.crc_ok, got.crc_ok);
                if (got.raw !== want.raw)
                    report_field("raw_value", want.raw, got.raw);
                if (got.reading !== want.reading)
                    report_field("reading_hundredths", want.reading, got.reading);
            end
        end
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            next_frame.kind = t_kind'(i_opcode);
            next_frame.hi   = i_data_high;
            next_frame.lo   = i_data_low;
            next_frame.chk  = i_crc_byte;
            reading_q.push_back(decode_frame(next_frame));
        end
    end

    initial begin
        t_kind kind;
        int    p;
        // Directed words: extremes of the raw word, each status bit pattern,
        // checksum mismatches, both measurement kinds
        for (int k = 0; k < 2; k++) begin
            kind = t_kind'(k);
            frame_q.push_back(make_frame(kind, 8'h00, 8'h00, 1'b1));
            frame_q.push_back(make_frame(kind, 8'hFF, 8'hFF, 1'b1));
            frame_q.push_back(make_frame(kind, 8'hFF, 8'hFC, 1'b1));
            frame_q.push_back(make_frame(kind, 8'h00, 8'h03, 1'b1));
            frame_q.push_back(make_frame(kind, 8'h80, 8'h01, 1'b1));
            frame_q.push_back(make_frame(kind, 8'h7F, 8'hFE, 1'b1));
            frame_q.push_back(make_frame(kind, 8'hFF, 8'hFF, 1'b0));
            frame_q.push_back(make_frame(kind, 8'h00, 8'h00, 1'b0));
            frame_q.push_back(make_frame(kind, 8'hA5, 8'h5A, 1'b0));
        end
        // Random words: mostly valid checksums, the rest corrupt or random
        for (int n = 0; n < 1350; n++) begin
            kind = t_kind'($urandom_range(0, 1));
            p = $urandom_range(0, 99);
            if (p < 70) begin
                frame_q.push_back(make_frame(kind, 8'($urandom), 8'($urandom), 1'b1));
            end else if (p < 90) begin
                frame_q.push_back(make_frame(kind, 8'($urandom), 8'($urandom), 1'b0));
            end else begin
                next_frame.kind = kind;
                next_frame.hi   = 8'($urandom);
                next_frame.lo   = 8'($urandom);
                next_frame.chk  = 8'($urandom);
                frame_q.push_back(next_frame);
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: wait until every word has gone in and every result came out
        while (frame_q.size() > 0 || i_valid || reading_q.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
